[hdl/opl_pkg.sv]
// ----------------------------------------------------------------------------
// opl_pkg
// Shared types and constants for the octree point locator.
// ----------------------------------------------------------------------------
package opl_pkg;

  // coordinate format
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 20;
  localparam int IPART_W   = COORD_W - 1 - FRAC_BITS;  // integer part of a non-negative coord

  // root grid size registers
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(16);

  // hierarchy memory and level table
  localparam int HIER_AW    = 16;
  localparam int HIER_DEPTH = 2 ** HIER_AW;
  localparam int WORD_W     = 32;
  localparam int OFS_W      = 16;
  localparam int NUM_LEVELS = 8;
  localparam int LVL_W      = $clog2(NUM_LEVELS);

  // cell index width: root index below 2047^3, or link target plus child number
  localparam int IND_W = 34;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X = 2'd0,
    CFG_SIZE_Y = 2'd1,
    CFG_SIZE_Z = 2'd2
  } cfg_idx_e;

  // request word actions
  typedef enum logic [1:0] {
    ACT_WR_WORD   = 2'd0,
    ACT_WR_OFFSET = 2'd1,
    ACT_LOCATE    = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

endpackage

[hdl/opl_req_if.sv]
// ----------------------------------------------------------------------------
// opl_req_if
// Request channel: valid/ready plus one request word.
// ----------------------------------------------------------------------------
interface opl_req_if;
  import opl_pkg::*;

  logic                        valid;
  logic                        ready;
  action_e                     action;
  logic [HIER_AW-1:0]          word_address;
  logic [LVL_W-1:0]            offset_level;
  logic [WORD_W-1:0]           write_word;
  logic signed [COORD_W-1:0]   coord_x;
  logic signed [COORD_W-1:0]   coord_y;
  logic signed [COORD_W-1:0]   coord_z;
  logic [LVL_W-1:0]            stop_level;

  modport source (
    output valid, action, word_address, offset_level, write_word,
    output coord_x, coord_y, coord_z, stop_level,
    input  ready
  );

  modport sink (
    input  valid, action, word_address, offset_level, write_word,
    input  coord_x, coord_y, coord_z, stop_level,
    output ready
  );

endinterface

[hdl/opl_rsp_if.sv]
// ----------------------------------------------------------------------------
// opl_rsp_if
// Response channel: valid/ready plus one locate result word.
// ----------------------------------------------------------------------------
interface opl_rsp_if;
  import opl_pkg::*;

  logic               valid;
  logic               ready;
  logic [LVL_W-1:0]   leaf_level;
  logic [OFS_W-1:0]   local_index;
  logic [OFS_W-1:0]   global_index;
  logic               outside;
  logic               bad_link;

  modport source (
    output valid, leaf_level, local_index, global_index, outside, bad_link,
    input  ready
  );

  modport sink (
    input  valid, leaf_level, local_index, global_index, outside, bad_link,
    output ready
  );

endinterface

[hdl/opl_root_index.sv]
// ----------------------------------------------------------------------------
// opl_root_index
// Root cell index ix + sx*(iy + sy*iz), three registered steps.
// ----------------------------------------------------------------------------
module opl_root_index (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [opl_pkg::SIZE_W-1:0]  size_x_i,
  input  logic [opl_pkg::SIZE_W-1:0]  size_y_i,
  input  logic [opl_pkg::IPART_W-1:0] ix_i,
  input  logic [opl_pkg::IPART_W-1:0] iy_i,
  input  logic [opl_pkg::IPART_W-1:0] iz_i,
  output logic                        done_o,
  output logic [opl_pkg::IND_W-1:0]   index_o
);
  import opl_pkg::*;

  localparam int P1_W = SIZE_W + IPART_W;
  localparam int T_W  = P1_W + 1;
  localparam int P2_W = SIZE_W + T_W;

  logic [2:0]       vld_q;
  logic [P1_W-1:0]  p1_q;
  logic [IND_W-1:0] p2_q;
  logic [IND_W-1:0] ind_q;
  logic [T_W-1:0]   t;
  logic [P2_W-1:0]  p2;

  // inputs hold steady for the whole computation
  assign t  = T_W'(iy_i) + T_W'(p1_q);
  assign p2 = P2_W'(size_x_i) * P2_W'(t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
      ind_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
      p1_q  <= P1_W'(size_y_i) * P1_W'(iz_i);
      p2_q  <= IND_W'(p2);
      ind_q <= IND_W'(ix_i) + p2_q;
    end
  end

  assign done_o  = vld_q[2];
  assign index_o = ind_q;

endmodule

[hdl/octree_point_locate.sv]
// ----------------------------------------------------------------------------
// octree_point_locate
// Point location in a linked octree hierarchy held in on-chip memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req_i     in   valid/ready    action, word_address, offset_level,
//                                write_word, coord_x/y/z, stop_level
//  rsp_o     out  valid/ready    leaf_level, local_index, global_index,
//                                outside, bad_link
//  cfg_*     in   write enable   root_size_x/y/z (index 0..2)
//
//  Write words (hierarchy word, level offset) give no result. A locate ending
//  at leaf level L runs from its accept to the next accept through: the accept
//  in S_IDLE, the check in S_CHK, the root index multiply in S_ROOT, an
//  address/read (S_ADDR) and an evaluate (S_EVAL) state per level with a
//  registered memory read, and the output register load in S_PEND. A bad link
//  at level L skips its evaluate state; an outside point goes from S_CHK to S_PEND.
//  Reset clears control and sets the size registers to 16; memory and level
//  offsets are undefined until written, so no clearing pass. A stalled
//  response holds in the output register; the next request is taken meanwhile
//  and its result waits in the pending state until the output register frees.
// ----------------------------------------------------------------------------
module octree_point_locate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [opl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [opl_pkg::SIZE_W-1:0]    cfg_wdata_i,
  opl_req_if.sink                       req_i,
  opl_rsp_if.source                     rsp_o
);
  import opl_pkg::*;

  localparam int FR_W = FRAC_BITS + 1;           // fraction range 0..one inclusive
  localparam int D_W  = FRAC_BITS + 2;           // doubled fraction
  localparam logic [D_W-1:0] FR_ONE = D_W'(1) << FRAC_BITS;
  localparam int SUM_W = IND_W + 1;
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_ROOT,
    S_ADDR,
    S_EVAL,
    S_PEND
  } state_e;

  // child choice: upper half only if 2f is strictly above one
  function automatic logic [FR_W:0] child_step(input logic [FR_W-1:0] f);
    logic [D_W-1:0] d;
    logic           c;
    logic [D_W-1:0] r;
    d = {f, 1'b0};
    c = (d > FR_ONE);
    r = c ? d - FR_ONE : d;
    return {c, r[FR_W-1:0]};
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RST;
      size_y_q <= SIZE_RST;
      size_z_q <= SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SIZE_X: size_x_q <= cfg_wdata_i;
        CFG_SIZE_Y: size_y_q <= cfg_wdata_i;
        CFG_SIZE_Z: size_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // request acceptance
  // ---------------------------------------------------------------------------
  state_e state_q;
  logic   req_acc;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // storage: hierarchy memory (registered read) and per-level start offsets
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0] hier_mem [HIER_DEPTH];
  logic [OFS_W-1:0]  ofs_q    [NUM_LEVELS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [HIER_AW-1:0] raddr;

  // write words address the full memory and table, no range check needed
  assign mem_we = req_acc && (req_i.action == ACT_WR_WORD);

  always_ff @(posedge clk_i) begin
    if (mem_we) hier_mem[req_i.word_address] <= req_i.write_word;
    if (mem_re) rdata_q <= hier_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_acc && (req_i.action == ACT_WR_OFFSET))
      ofs_q[req_i.offset_level] <= req_i.write_word[OFS_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // locate datapath
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [LVL_W-1:0]   stop_q;
  logic [LVL_W-1:0]   level_q;
  logic [IND_W-1:0]   ind_q;
  logic [OFS_W-1:0]   addr_q;            // low bits of the last address read
  logic [FR_W-1:0]    fx_q, fy_q, fz_q;

  // pending result
  logic [LVL_W-1:0]   p_level_q;
  logic [OFS_W-1:0]   p_local_q, p_global_q;
  logic               p_out_q, p_bad_q;

  // output register
  logic               ov_q;
  logic [LVL_W-1:0]   o_level_q;
  logic [OFS_W-1:0]   o_local_q, o_global_q;
  logic               o_out_q, o_bad_q;

  // root index unit
  logic               root_start;
  logic               root_done;
  logic [IND_W-1:0]   root_ind;
  logic [IPART_W-1:0] ix, iy, iz;

  assign ix = cx_q[COORD_W-2:FRAC_BITS];
  assign iy = cy_q[COORD_W-2:FRAC_BITS];
  assign iz = cz_q[COORD_W-2:FRAC_BITS];

  opl_root_index u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (root_start),
    .size_x_i (size_x_q),
    .size_y_i (size_y_q),
    .ix_i     (ix),
    .iy_i     (iy),
    .iz_i     (iz),
    .done_o   (root_done),
    .index_o  (root_ind)
  );

  // outside test: any sign bit set or integer part at/above root size
  logic outside;
  assign outside = cx_q[COORD_W-1] || cy_q[COORD_W-1] || cz_q[COORD_W-1] ||
                   (IND_W'(ix) >= IND_W'(size_x_q)) ||
                   (IND_W'(iy) >= IND_W'(size_y_q)) ||
                   (IND_W'(iz) >= IND_W'(size_z_q));
  assign root_start = (state_q == S_CHK) && !outside;

  // address of current cell and range check
  logic [SUM_W-1:0] addr_sum;
  logic             addr_bad;
  assign addr_sum = SUM_W'(ofs_q[level_q]) + SUM_W'(ind_q);
  assign addr_bad = (addr_sum[SUM_W-1:HIER_AW] != '0);
  assign raddr    = addr_sum[HIER_AW-1:0];
  assign mem_re   = (state_q == S_ADDR) && !addr_bad;

  // evaluate: link test and child selection
  logic              is_link;
  logic [FR_W:0]     sx, sy, sz;
  logic [2:0]        sid;
  logic [IND_W-1:0]  ind_next;
  assign is_link  = rdata_q[WORD_W-1] || (rdata_q == '0);
  assign sx       = child_step(fx_q);
  assign sy       = child_step(fy_q);
  assign sz       = child_step(fz_q);
  assign sid      = {sz[FR_W], sy[FR_W], sx[FR_W]};
  assign ind_next = IND_W'(rdata_q[WORD_W-2:0]) + IND_W'(sid);

  logic out_free;
  assign out_free = !ov_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      stop_q     <= '0;
      level_q    <= '0;
      ind_q      <= '0;
      addr_q     <= '0;
      fx_q       <= '0;
      fy_q       <= '0;
      fz_q       <= '0;
      p_level_q  <= '0;
      p_local_q  <= '0;
      p_global_q <= '0;
      p_out_q    <= 1'b0;
      p_bad_q    <= 1'b0;
      ov_q       <= 1'b0;
      o_level_q  <= '0;
      o_local_q  <= '0;
      o_global_q <= '0;
      o_out_q    <= 1'b0;
      o_bad_q    <= 1'b0;
    end else begin
      // drained word; a pending result reloads the register in S_PEND instead
      if (ov_q && rsp_o.ready && (state_q != S_PEND)) ov_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (req_acc && (req_i.action == ACT_LOCATE)) begin
            cx_q    <= req_i.coord_x;
            cy_q    <= req_i.coord_y;
            cz_q    <= req_i.coord_z;
            stop_q  <= (req_i.stop_level > LVL_MAX) ? LVL_MAX : req_i.stop_level;
            level_q <= '0;
            state_q <= S_CHK;
          end
        end

        S_CHK: begin
          fx_q <= FR_W'(cx_q[FRAC_BITS-1:0]);
          fy_q <= FR_W'(cy_q[FRAC_BITS-1:0]);
          fz_q <= FR_W'(cz_q[FRAC_BITS-1:0]);
          if (outside) begin
            p_level_q  <= '0;
            p_local_q  <= '0;
            p_global_q <= '0;
            p_out_q    <= 1'b1;
            p_bad_q    <= 1'b0;
            state_q    <= S_PEND;
          end else begin
            state_q <= S_ROOT;
          end
        end

        S_ROOT: begin
          if (root_done) begin
            ind_q   <= root_ind;
            state_q <= S_ADDR;
          end
        end

        S_ADDR: begin
          addr_q <= addr_sum[OFS_W-1:0];
          if (addr_bad) begin
            p_level_q  <= level_q;
            p_local_q  <= ind_q[OFS_W-1:0];
            p_global_q <= addr_sum[OFS_W-1:0];
            p_out_q    <= 1'b0;
            p_bad_q    <= 1'b1;
            state_q    <= S_PEND;
          end else begin
            state_q <= S_EVAL;
          end
        end

        S_EVAL: begin
          if (!is_link || (level_q >= stop_q)) begin
            p_level_q  <= level_q;
            p_local_q  <= ind_q[OFS_W-1:0];
            p_global_q <= addr_q;
            p_out_q    <= 1'b0;
            p_bad_q    <= 1'b0;
            state_q    <= S_PEND;
          end else begin
            fx_q    <= sx[FR_W-1:0];
            fy_q    <= sy[FR_W-1:0];
            fz_q    <= sz[FR_W-1:0];
            ind_q   <= ind_next;
            level_q <= level_q + LVL_W'(1);
            state_q <= S_ADDR;
          end
        end

        S_PEND: begin
          if (out_free) begin
            ov_q       <= 1'b1;
            o_level_q  <= p_level_q;
            o_local_q  <= p_local_q;
            o_global_q <= p_global_q;
            o_out_q    <= p_out_q;
            o_bad_q    <= p_bad_q;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = ov_q;
  assign rsp_o.leaf_level   = o_level_q;
  assign rsp_o.local_index  = o_local_q;
  assign rsp_o.global_index = o_global_q;
  assign rsp_o.outside      = o_out_q;
  assign rsp_o.bad_link     = o_bad_q;

endmodule

[tb/tb_octree_point_locate.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_octree_point_locate
// Self-checking bench for the octree point locator. Request words (hierarchy
// writes, level offset writes, locates, no-ops) go in over the request
// channel. A scoreboard keeps its own copy of the hierarchy memory, the level
// offsets and the root grid size, predicts every locate result and checks the
// response words in order. Locates are shaped so that every word they read
// has been written first. The run steps through several root grid sizes and
// idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_octree_point_locate;
  import opl_pkg::*;

  localparam int CLK_HALF   = 2;       // 4 ns clock
  localparam int CYCLE_CAP  = 600000;  // watchdog, far above a slow run
  localparam int DRAIN_WAIT = 40;      // settle time after the last owed result
  localparam int HOLD_LEN   = 300;     // long response hold-off
  localparam int N_PHASES   = 8;
  localparam int ERR_SHOWN  = 30;      // mismatch lines printed at most

  localparam logic [31:0]     FRAC_MASK = (32'd1 << FRAC_BITS) - 32'd1;
  localparam logic [31:0]     FRAC_HALF = 32'd1 << (FRAC_BITS - 1);
  localparam longint unsigned FRAC_ONE  = 64'd1 << FRAC_BITS;

  // one request word as the scoreboard sees it (coords kept as raw bits)
  typedef struct packed {
    action_e             action;
    logic [HIER_AW-1:0]  word_address;
    logic [LVL_W-1:0]    offset_level;
    logic [WORD_W-1:0]   write_word;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [LVL_W-1:0]    stop_level;
  } req_word_t;

  // one locate result word
  typedef struct packed {
    logic [LVL_W-1:0] leaf_level;
    logic [OFS_W-1:0] local_index;
    logic [OFS_W-1:0] global_index;
    logic             outside;
    logic             bad_link;
  } cell_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the block state plus the queue of locate results
  // still owed by the block.
  // --------------------------------------------------------------------------
  class octree_tracker;
    logic [WORD_W-1:0] hier_mem [HIER_DEPTH];
    bit                hier_set [HIER_DEPTH];
    logic [OFS_W-1:0]  lvl_ofs  [NUM_LEVELS];
    int unsigned       size_x = SIZE_RST;
    int unsigned       size_y = SIZE_RST;
    int unsigned       size_z = SIZE_RST;
    cell_word_t        cells_due [$];
    int unsigned       n_checked, n_outside, n_bad, n_writes, deepest, n_errors;

    // doubles a cell fraction, returns the child bit; 2f == one stays low
    function bit split_frac(inout longint unsigned f);
      longint unsigned twice;
      twice = f << 1;
      if (twice > FRAC_ONE) begin
        f = twice - FRAC_ONE;
        return 1'b1;
      end
      f = twice;
      return 1'b0;
    endfunction

    // walks the hierarchy for one locate; gap flags a read of a word that
    // was never written (the result is then meaningless)
    function cell_word_t find_leaf(req_word_t r, output bit gap,
                                   output int unsigned gap_addr);
      cell_word_t        res;
      longint unsigned   fx, fy, fz, ix, iy, iz, ind, addr;
      int unsigned       lvl, stop;
      logic [WORD_W-1:0] w;
      logic [2:0]        sid;
      res = '0;
      gap = 1'b0;
      gap_addr = 0;
      ix = 64'(r.coord_x >> FRAC_BITS);
      iy = 64'(r.coord_y >> FRAC_BITS);
      iz = 64'(r.coord_z >> FRAC_BITS);
      if (r.coord_x[COORD_W-1] || r.coord_y[COORD_W-1] || r.coord_z[COORD_W-1] ||
          ix >= 64'(size_x) || iy >= 64'(size_y) || iz >= 64'(size_z)) begin
        res.outside = 1'b1;
        return res;
      end
      fx = 64'(r.coord_x & FRAC_MASK);
      fy = 64'(r.coord_y & FRAC_MASK);
      fz = 64'(r.coord_z & FRAC_MASK);
      ind = ix + 64'(size_x) * (iy + 64'(size_y) * iz);
      stop = (r.stop_level > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : r.stop_level;
      lvl = 0;
      addr = 0;
      forever begin
        addr = 64'(lvl_ofs[lvl]) + ind;
        if (addr >= 64'(HIER_DEPTH)) begin
          res.bad_link = 1'b1;
          break;
        end
        if (!hier_set[addr]) begin
          gap = 1'b1;
          gap_addr = 32'(addr);
          break;
        end
        w = hier_mem[addr];
        // leaf word, or stop level reached on a link
        if (!(w[WORD_W-1] || w == '0) || lvl >= stop) break;
        sid[0] = split_frac(fx);
        sid[1] = split_frac(fy);
        sid[2] = split_frac(fz);
        ind = 64'(w[WORD_W-2:0]) + 64'(sid);
        lvl++;
      end
      res.leaf_level   = LVL_W'(lvl);
      res.local_index  = ind[OFS_W-1:0];
      res.global_index = addr[OFS_W-1:0];
      return res;
    endfunction

    // accepted request word: update the mirror or queue the expected result
    function void note_word(req_word_t r);
      bit          gap;
      int unsigned gap_addr;
      case (r.action)
        ACT_WR_WORD: begin
          hier_mem[r.word_address] = r.write_word;
          hier_set[r.word_address] = 1'b1;
          n_writes++;
        end
        ACT_WR_OFFSET: begin
          lvl_ofs[r.offset_level] = r.write_word[OFS_W-1:0];
          n_writes++;
        end
        ACT_LOCATE: cells_due.push_back(find_leaf(r, gap, gap_addr));
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        n_errors++;
        if (n_errors <= ERR_SHOWN)
          $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(cell_word_t got);
      cell_word_t want;
      if (cells_due.size() == 0) begin
        n_errors++;
        if (n_errors <= ERR_SHOWN)
          $display("%0t  unexpected result: expected none, actual %p", $time, got);
        return;
      end
      want = cells_due.pop_front();
      n_checked++;
      if (want.outside) n_outside++;
      if (want.bad_link) n_bad++;
      if (want.leaf_level > deepest) deepest = want.leaf_level;
      compare_field("leaf_level",   32'(want.leaf_level),   32'(got.leaf_level));
      compare_field("local_index",  32'(want.local_index),  32'(got.local_index));
      compare_field("global_index", 32'(want.global_index), 32'(got.global_index));
      compare_field("outside",      32'(want.outside),      32'(got.outside));
      compare_field("bad_link",     32'(want.bad_link),     32'(got.bad_link));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0]    cfg_wdata_i;

  opl_req_if req_if ();
  opl_rsp_if rsp_if ();

  octree_point_locate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  octree_tracker tracker;

  // traffic shaping knobs, set per phase by the stimulus process
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_reqs    = 0;   // bumped to ask the receiver for a hold-off
  bit          offering     = 1'b0;
  int unsigned n_items      = 0;
  int unsigned n_settings   = 0;
  int unsigned cycle_count;

  // root grid per phase; phase 0 runs on the reset size
  int unsigned ph_sx    [N_PHASES] = '{16, 1, 1024,  40, 0, 2047, 8, 1024};
  int unsigned ph_sy    [N_PHASES] = '{16, 1, 1024,  25, 8,    3, 8,    1};
  int unsigned ph_sz    [N_PHASES] = '{16, 1, 1024,   7, 8,    1, 8,    1};
  int unsigned ph_items [N_PHASES] = '{260, 150, 60, 260, 40, 180, 220, 80};

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // offers one word, holds it until taken, then maybe idles a while
  task automatic send(req_word_t r);
    req_if.valid        <= 1'b1;
    req_if.action       <= r.action;
    req_if.word_address <= r.word_address;
    req_if.offset_level <= r.offset_level;
    req_if.write_word   <= r.write_word;
    req_if.coord_x      <= r.coord_x;
    req_if.coord_y      <= r.coord_y;
    req_if.coord_z      <= r.coord_z;
    req_if.stop_level   <= r.stop_level;
    offering = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    tracker.note_word(r);
    if (r.action != ACT_NONE) n_items++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
  endtask

  task automatic quiet();
    if (offering) begin
      req_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // stop offering, wait for every owed result, then let the pipe settle
  task automatic wait_drained();
    quiet();
    while (tracker.cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // random fill for the fields an action does not use
  function automatic req_word_t noise_word();
    req_word_t r;
    r.action       = action_e'($urandom_range(0, 3));
    r.word_address = HIER_AW'($urandom);
    r.offset_level = LVL_W'($urandom);
    r.write_word   = $urandom;
    r.coord_x      = $urandom;
    r.coord_y      = $urandom;
    r.coord_z      = $urandom;
    r.stop_level   = LVL_W'($urandom);
    return r;
  endfunction

  // hierarchy word mix: links near and far, zero links, float leaves
  function automatic logic [WORD_W-1:0] random_node();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return {1'b1, 31'($urandom_range(0, 255) * 8)};  // shared octets
    if (pick < 50) return {1'b1, 31'($urandom_range(0, HIER_DEPTH - 8))};
    if (pick < 56) return {1'b1, 31'($urandom)};                     // mostly off the end
    if (pick < 60) return 32'hC479_C000;                              // -999.0f
    if (pick < 66) return '0;                                         // 0.0f links to 0
    if (pick < 72) return 32'h3F80_0000;                              // 1.0f
    if (pick < 76) return 32'h4000_0000;                              // 2.0f
    return {1'b0, 31'($urandom_range(1, 32'h7FFF_FFFF))};
  endfunction

  // coordinate along one axis; mostly inside, with fraction corner cases
  function automatic logic [31:0] rand_coord(int unsigned size);
    logic [31:0] ipart, frac;
    ipart = (size == 0) ? 32'd0 : $urandom_range(0, size - 1);
    frac  = $urandom & FRAC_MASK;
    case ($urandom_range(0, 39))
      0: return $urandom | 32'h8000_0000;       // negative
      1: return (size << FRAC_BITS) | frac;     // just past the grid
      2: return $urandom;
      3: frac = '0;
      4: frac = FRAC_MASK;
      5: frac = FRAC_HALF;                      // fraction hits one next level
      6: frac = FRAC_HALF >> 1;                 // ... one level later
      default: ;
    endcase
    return (ipart << FRAC_BITS) | frac;
  endfunction

  function automatic logic [LVL_W-1:0] rand_stop();
    return $urandom_range(0, 1) ? LVL_W'(NUM_LEVELS - 1) : LVL_W'($urandom);
  endfunction

  task automatic put_word(logic [HIER_AW-1:0] a, logic [WORD_W-1:0] w);
    req_word_t r;
    r = noise_word();
    r.action       = ACT_WR_WORD;
    r.word_address = a;
    r.write_word   = w;
    send(r);
  endtask

  task automatic put_offset(int unsigned lvl, logic [OFS_W-1:0] v);
    req_word_t r;
    r = noise_word();
    r.action       = ACT_WR_OFFSET;
    r.offset_level = LVL_W'(lvl);
    r.write_word   = {16'($urandom), v};   // upper half is ignored by the block
    send(r);
  endtask

  // locate a point; any word the walk would read unwritten gets written first
  task automatic locate_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [LVL_W-1:0] stop);
    req_word_t   r;
    bit          gap;
    int unsigned gap_addr;
    r = noise_word();
    r.action     = ACT_LOCATE;
    r.coord_x    = x;
    r.coord_y    = y;
    r.coord_z    = z;
    r.stop_level = stop;
    forever begin
      void'(tracker.find_leaf(r, gap, gap_addr));
      if (!gap) break;
      put_word(HIER_AW'(gap_addr), random_node());
    end
    send(r);
  endtask

  task automatic set_root(int unsigned sx, int unsigned sy, int unsigned sz);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SIZE_X;
    cfg_wdata_i <= SIZE_W'(sx);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIZE_Y;
    cfg_wdata_i <= SIZE_W'(sy);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIZE_Z;
    cfg_wdata_i <= SIZE_W'(sz);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.size_x = sx % 2048;
    tracker.size_y = sy % 2048;
    tracker.size_z = sz % 2048;
    n_settings++;
  endtask

  // fresh level table; the last style scatters offsets so bad links show up
  task automatic set_offsets();
    int unsigned style;
    style = $urandom_range(0, 3);
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
      case (style)
        0: put_offset(lvl, OFS_W'(lvl * 4096 + $urandom_range(0, 1023)));
        1: put_offset(lvl, OFS_W'($urandom_range(0, 16383)));
        2: put_offset(lvl, OFS_W'(lvl * 512));
        default: put_offset(lvl, (lvl == 0) ? '0 : OFS_W'($urandom));
      endcase
    end
  endtask

  // hand-built cases on the reset grid of 16 x 16 x 16
  task automatic directed();
    for (int lvl = 0; lvl < NUM_LEVELS; lvl++) put_offset(lvl, OFS_W'(lvl * 4096));
    put_word(16'h0000, 32'h8000_0100);   // root cell 0 links to octet 0x100
    put_word(16'h1107, 32'h3F80_0000);   // upper corner child is a leaf
    locate_point(32'h000C_0000, 32'h000C_0000, 32'h000C_0000, 3'd7);  // leaf at level 1
    locate_point(32'h000C_0000, 32'h000C_0000, 32'h000C_0000, 3'd0);  // stop on a link
    put_word(16'h0001, 32'hC479_C000);   // -999.0f: link far past the memory
    locate_point(32'h0018_0000, 32'h0004_0000, 32'h0004_0000, 3'd7);  // bad link
    put_word(16'h0002, 32'h0000_0000);   // zero word counts as link to 0
    locate_point(32'h0028_0000, FRAC_HALF, FRAC_HALF, 3'd7);          // fraction of one
    locate_point(32'hFFFF_FFFF, 32'd0, 32'd0, 3'd7);                  // negative x
    locate_point(32'h0100_0000, 32'd0, 32'd0, 3'd3);                  // x == size
    locate_point(32'd0, 32'h7FFF_FFFF, 32'd0, 3'd7);                  // y way out
    locate_point(32'd0, 32'd0, 32'h0100_0000, 3'd7);                  // z == size
    locate_point({12'd15, 20'hF_FFFF}, {12'd15, 20'hF_FFFF}, {12'd15, 20'hF_FFFF}, 3'd7);
    send('{action: ACT_NONE, default: '0});
    locate_point(32'd0, 32'd0, 32'd0, 3'd7);
  endtask

  // random traffic for one phase; idle pattern follows the phase number.
  // The phase budget counts every request word but no-ops, fill writes included.
  task automatic run_phase(int unsigned p);
    int unsigned base, pick;
    bit          mid_done;
    req_word_t   r;
    tx_idle_pct  = (p % 4 == 1) ? 75 : (p % 4 == 3) ? 16 : 0;
    rx_stall_pct = (p % 4 == 2) ? 75 : (p % 4 == 3) ? 16 : 0;
    base = n_items;
    mid_done = 1'b0;
    while (n_items - base < ph_items[p]) begin
      // halfway: either a long response hold-off while we keep pushing,
      // or a full pause until the block is empty
      if (!mid_done && n_items - base >= ph_items[p] / 2) begin
        mid_done = 1'b1;
        if (tx_idle_pct == 0) hold_reqs++;
        else wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        locate_point(rand_coord(tracker.size_x), rand_coord(tracker.size_y),
                     rand_coord(tracker.size_z), rand_stop());
      end else if (pick < 92) begin
        put_word(HIER_AW'($urandom), $urandom_range(0, 1) ? random_node() : $urandom);
      end else if (pick < 96) begin
        put_offset($urandom_range(0, NUM_LEVELS - 1),
                   OFS_W'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 8191)));
      end else begin
        r = noise_word();
        r.action = ACT_NONE;
        send(r);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready, long hold-off on request, result checking
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold_left, hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      tracker.check_result({rsp_if.leaf_level, rsp_if.local_index, rsp_if.global_index,
                            rsp_if.outside, rsp_if.bad_link});
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t  timeout, %0d locate results still owed", $time, tracker.cells_due.size());
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_SIZE_X;
    cfg_wdata_i         <= '0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_NONE;
    req_if.word_address <= '0;
    req_if.offset_level <= '0;
    req_if.write_word   <= '0;
    req_if.coord_x      <= '0;
    req_if.coord_y      <= '0;
    req_if.coord_z      <= '0;
    req_if.stop_level   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    for (int p = 0; p < N_PHASES; p++) begin
      // sizes change only with the block empty
      if (p != 0) begin
        wait_drained();
        set_root(ph_sx[p], ph_sy[p], ph_sz[p]);
      end
      set_offsets();
      run_phase(p);
    end
    wait_drained();

    $display("locates checked: %0d (%0d outside, %0d bad link), deepest leaf level %0d",
             tracker.n_checked, tracker.n_outside, tracker.n_bad, tracker.deepest);
    $display("request words: %0d, table writes: %0d, root grid settings: %0d",
             n_items, tracker.n_writes, n_settings);
    if (tracker.n_errors == 0 && tracker.cells_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
